// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and defaults for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FUNC_W         = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_PEEK       = 3'd4
	} func_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic read;
		logic load;
	} deq_cmd_t;

endpackage

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: capture, pointer update, store read, result load.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output deq_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_READ,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   can_load;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign can_load = !m_tvalid_q || m_tready;

	assign cmd.capture = s_tready && s_tvalid;
	assign cmd.update  = (state_q == ST_UPDATE);
	assign cmd.read    = (state_q == ST_READ);
	assign cmd.load    = (state_q == ST_LOAD) && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/deq_dp.sv =====
// ----------------------------------------------------------------------------
// deq_dp
// Ring store, head pointer, entry count and result register.
// ----------------------------------------------------------------------------
module deq_dp import deq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int PW         = $clog2(DEPTH),
	parameter int CW         = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  deq_cmd_t              cmd,
	input  logic [FUNC_W-1:0]     func,
	input  logic [DATA_WIDTH-1:0] data_word,
	output logic                  ok,
	output logic [CW-1:0]         count,
	output logic                  is_empty,
	output logic [DATA_WIDTH-1:0] front_word,
	output logic [DATA_WIDTH-1:0] back_word
);

	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW:0]   WRAP     = (CW + 1)'(DEPTH);

	function automatic logic [PW-1:0] ring_wrap(input logic [CW:0] s);
		logic [CW:0] t;
		t = (s >= WRAP) ? s - WRAP : s;
		return t[PW-1:0];
	endfunction

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [FUNC_W-1:0]     func_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [PW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic                  ok_q;
	logic [DATA_WIDTH-1:0] rd_front_q;
	logic [DATA_WIDTH-1:0] rd_back_q;

	logic                  ok_o_q;
	logic [CW-1:0]         count_o_q;
	logic                  empty_o_q;
	logic [DATA_WIDTH-1:0] front_o_q;
	logic [DATA_WIDTH-1:0] back_o_q;

	logic          full;
	logic          empty;
	logic [CW:0]   head_ext;
	logic [CW:0]   count_ext;
	logic          nxt_ok;
	logic [PW-1:0] nxt_head;
	logic [CW-1:0] nxt_count;
	logic          we;
	logic [PW-1:0] waddr;
	logic [PW-1:0] back_idx;

	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign head_ext  = (CW + 1)'(head_q);
	assign count_ext = (CW + 1)'(count_q);
	assign back_idx  = ring_wrap(head_ext + count_ext - (CW + 1)'(1));

	always_comb begin
		nxt_ok    = 1'b0;
		nxt_head  = head_q;
		nxt_count = count_q;
		we        = 1'b0;
		waddr     = ring_wrap(head_ext + count_ext);
		case (func_q)
			FN_PUSH_FRONT: begin
				if (!full) begin
					nxt_head  = (head_q == '0) ? LAST_IDX : head_q - PW'(1);
					waddr     = nxt_head;
					we        = 1'b1;
					nxt_count = count_q + CW'(1);
					nxt_ok    = 1'b1;
				end
			end
			FN_PUSH_BACK: begin
				if (!full) begin
					we        = 1'b1;
					nxt_count = count_q + CW'(1);
					nxt_ok    = 1'b1;
				end
			end
			FN_POP_FRONT: begin
				if (!empty) begin
					nxt_head  = ring_wrap(head_ext + (CW + 1)'(1));
					nxt_count = count_q - CW'(1);
					nxt_ok    = 1'b1;
				end
			end
			FN_POP_BACK: begin
				if (!empty) begin
					nxt_count = count_q - CW'(1);
					nxt_ok    = 1'b1;
				end
			end
			FN_PEEK: begin
				nxt_ok = 1'b1;
			end
			default: begin
				nxt_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.update) begin
			head_q  <= nxt_head;
			count_q <= nxt_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			word_q <= data_word;
		end
		if (cmd.update) begin
			ok_q <= nxt_ok;
			if (we) begin
				mem[waddr] <= word_q;
			end
		end
		if (cmd.read) begin
			rd_front_q <= mem[head_q];
			rd_back_q  <= mem[back_idx];
		end
		if (cmd.load) begin
			ok_o_q    <= ok_q;
			count_o_q <= count_q;
			empty_o_q <= empty;
			front_o_q <= empty ? '0 : rd_front_q;
			back_o_q  <= empty ? '0 : rd_back_q;
		end
	end

	assign ok         = ok_o_q;
	assign count      = count_o_q;
	assign is_empty   = empty_o_q;
	assign front_word = front_o_q;
	assign back_word  = back_o_q;

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// An accepted request is captured, then runs through the pointer update, the
// registered two-port store read and the result load onto the master side;
// a further request is accepted only after that result load is done.
// A new request is taken while the previous result still waits on m_tready.
// Reset (arst_n low) empties the queue and clears the handshake state; the
// store contents are not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue on a ring store with front/back push and pop, and peek.
// ----------------------------------------------------------------------------
module double_ended_queue_unit import deq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int CW         = $clog2(DEPTH + 1),
	parameter int IN_TW      = ((FUNC_W + DATA_WIDTH + 7) / 8) * 8,
	parameter int OUT_TW     = ((CW + 2 + 2 * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,  // func, data_word
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata   // ok, count, is_empty, front_word, back_word
);

	localparam int OUT_W = CW + 2 + 2 * DATA_WIDTH;

	deq_cmd_t              cmd;
	logic                  ok;
	logic [CW-1:0]         count;
	logic                  is_empty;
	logic [DATA_WIDTH-1:0] front_word;
	logic [DATA_WIDTH-1:0] back_word;
	logic [OUT_W-1:0]      res;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	deq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.PW         ($clog2(DEPTH)),
		.CW         (CW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (s_tdata[FUNC_W-1:0]),
		.data_word  (s_tdata[FUNC_W +: DATA_WIDTH]),
		.ok         (ok),
		.count      (count),
		.is_empty   (is_empty),
		.front_word (front_word),
		.back_word  (back_word)
	);

	assign res     = {back_word, front_word, is_empty, count, ok};
	assign m_tdata = OUT_TW'(res);

endmodule
